FILE: rtl/occupancy_bitmap_voxel_scan_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the occupancy bitmap voxel scan.
// Each check is sampled on the rising clock and is held off during reset.
// ----------------------------------------------------------------------------
`ifndef OCCUPANCY_BITMAP_VOXEL_SCAN_TOP_ASSERT_SVH
`define OCCUPANCY_BITMAP_VOXEL_SCAN_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define OBVS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("occupancy scan check failed");

`define OBVS_ASSERT_NEVER(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("occupancy scan forbidden condition seen");

`else

`define OBVS_ASSERT(lbl, clk, rst_n, prop)

`define OBVS_ASSERT_NEVER(lbl, clk, rst_n, prop)

`endif

`endif

FILE: rtl/obvs_pkg.sv
// ----------------------------------------------------------------------------
// Occupancy bitmap voxel scan package
// Request types, controller interface types and the Morton decode helper.
// ----------------------------------------------------------------------------
`default_nettype none

package obvs_pkg;

  localparam int ChunkW = 9;
  localparam int WordW  = 64;
  localparam int IdxW   = 15;
  localparam int CoordW = 5;

  typedef struct packed {
    logic [ChunkW-1:0] chunk_number;
    logic [WordW-1:0]  occupancy_word;
  } in_item_t;

  typedef struct packed {
    logic [IdxW-1:0]   voxel_index;
    logic [CoordW-1:0] coord_x;
    logic [CoordW-1:0] coord_y;
    logic [CoordW-1:0] coord_z;
    logic              last_of_word;
  } out_item_t;

  typedef enum logic {
    StIdle,
    StScan
  } state_e;

  typedef struct packed {
    logic load;
    logic step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic start_ok;
    logic rest_zero;
    logic out_free;
  } ctrl_status_t;

  // Masks of the standard three-way bit compaction.
  localparam logic [31:0] MortonMask0 = 32'h0924_9249;
  localparam logic [31:0] MortonMask1 = 32'h030C_30C3;
  localparam logic [31:0] MortonMask2 = 32'h0300_F00F;
  localparam logic [31:0] MortonMask3 = 32'h0000_00FF;

  // Gathers every third index bit, starting at the given offset.
  function automatic logic [CoordW-1:0] morton_coord(input logic [IdxW-1:0] idx,
                                                     input logic [1:0] offset);
    logic [31:0] v;
    v = (32'(idx) >> offset) & MortonMask0;
    v = (v | (v >> 2)) & MortonMask1;
    v = (v | (v >> 4)) & MortonMask2;
    v = (v | (v >> 8)) & MortonMask3;
    return v[CoordW-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/occupancy_bitmap_voxel_scan_top.sv
// ----------------------------------------------------------------------------
// Occupancy bitmap voxel scan, top level
// The shift scan steps through a word one bit per cycle unless the output register
// stalls it; an empty word or an out-of-range chunk is taken without a scan, and a
// new word is taken only once the controller is back in idle. Reset clears the
// controller and output valid; no sweep.
// ----------------------------------------------------------------------------
`default_nettype none

// The block takes one occupancy word per request and returns one result
// request for every set bit, lowest bit first. Each result carries the
// linear voxel index, the three Morton-decoded coordinates and a flag on
// the highest set bit of the word.
//
// The controller waits in idle with the input ready high. On acceptance
// the datapath loads the word, masked to BITS_PER_WORD bits, and the base
// index chunk_number * BITS_PER_WORD. If the chunk lies inside the grid
// and the word has a set bit, the controller enters the scan state and
// then steps once per cycle unless stalled: the word shifts right by one
// and the bit counter advances. Whenever the bit leaving the word is set,
// a result is written into the output register. The scan stops on the
// step that finds no set bit above the current one, so the last result
// carries the last flag and the controller is idle in the next cycle.
//
// The output register decouples the two sides: a new word can be taken
// while the final result of the previous one still waits. While an
// earlier result is still held there and not taken, the scan stalls.
module occupancy_bitmap_voxel_scan_top #(
  parameter int BITS_PER_WORD = 64,
  parameter int WORD_COUNT    = 512
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  obvs_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output obvs_pkg::out_item_t out_data_o
);
  import obvs_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  // Sequencing of the scan.
  obvs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Word shifter, index arithmetic, Morton decode and output register.
  obvs_datapath #(
    .BITS_PER_WORD (BITS_PER_WORD),
    .WORD_COUNT    (WORD_COUNT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

FILE: rtl/obvs_ctrl.sv
// ----------------------------------------------------------------------------
// Occupancy scan controller
// Accepts a request when idle and steps the datapath through the word.
// ----------------------------------------------------------------------------
`default_nettype none

`include "occupancy_bitmap_voxel_scan_top_assert.svh"

module obvs_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  obvs_pkg::ctrl_status_t status_i,
  output obvs_pkg::ctrl_cmd_t   cmd_o
);
  import obvs_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (status_i.start_ok) begin
            state_d = StScan;
          end
        end
      end
      StScan: begin
        // Hold the scan while a result still waits at the output.
        if (status_i.out_free) begin
          cmd_o.step = 1'b1;
          if (status_i.rest_zero) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  `OBVS_ASSERT(a_step_only_when_free, clk_i, rst_ni,
               cmd_o.step |-> (status_i.out_free && state_q == StScan))
  `OBVS_ASSERT(a_last_bit_ends_scan, clk_i, rst_ni,
               (cmd_o.step && status_i.rest_zero) |=> (state_q == StIdle))
  `OBVS_ASSERT_NEVER(a_load_while_scanning, clk_i, rst_ni,
                     cmd_o.load && state_q == StScan)

endmodule

`default_nettype wire

FILE: rtl/obvs_datapath.sv
// ----------------------------------------------------------------------------
// Occupancy scan datapath
// Shifts the word one bit per step and registers one result per set bit.
// ----------------------------------------------------------------------------
`default_nettype none

module obvs_datapath #(
  parameter int BITS_PER_WORD = 64,
  parameter int WORD_COUNT    = 512
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  obvs_pkg::in_item_t     in_data_i,
  input  obvs_pkg::ctrl_cmd_t    cmd_i,
  output obvs_pkg::ctrl_status_t status_o,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  output obvs_pkg::out_item_t    out_data_o
);
  import obvs_pkg::*;

  localparam int CntW = $clog2(BITS_PER_WORD);

  logic [BITS_PER_WORD-1:0] word_q;
  logic [CntW-1:0]          bit_q;
  logic [IdxW-1:0]          base_q, base_d;
  logic [IdxW-1:0]          idx;
  logic                     chunk_ok;
  logic                     out_valid_q, out_valid_d;
  logic                     emit;
  out_item_t                out_q;

  // Chunks past the grid are dropped; bits above the word size are ignored.
  assign chunk_ok = {4'b0, in_data_i.chunk_number} < 13'(WORD_COUNT);
  assign base_d   = IdxW'(32'(in_data_i.chunk_number) * 32'(BITS_PER_WORD));
  assign idx      = base_q + IdxW'(bit_q);
  assign emit     = cmd_i.step && word_q[0];

  assign status_o.start_ok  = chunk_ok &&
                              (in_data_i.occupancy_word[BITS_PER_WORD-1:0] != '0);
  assign status_o.rest_zero = (word_q[BITS_PER_WORD-1:1] == '0);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      base_q <= base_d;
      word_q <= in_data_i.occupancy_word[BITS_PER_WORD-1:0];
      bit_q  <= '0;
    end else if (cmd_i.step) begin
      word_q <= word_q >> 1;
      bit_q  <= bit_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q.voxel_index  <= idx;
      out_q.coord_x      <= morton_coord(idx, 2'd0);
      out_q.coord_y      <= morton_coord(idx, 2'd1);
      out_q.coord_z      <= morton_coord(idx, 2'd2);
      out_q.last_of_word <= status_o.rest_zero;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
